FILE: hdl/rms_level_meter_peak_decay_macros.svh
// assertion macros for the rms level meter
`ifndef RMS_LEVEL_METER_PEAK_DECAY_MACROS_SVH
`define RMS_LEVEL_METER_PEAK_DECAY_MACROS_SVH

// same-cycle implication
`define RLM_ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("rms level meter: check failed");

// next-cycle implication
`define RLM_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("rms level meter: check failed");

`endif

FILE: hdl/rmslm_pkg.sv
// shared types and constants of the rms level meter
`default_nettype none

package rmslm_pkg;

    localparam int SUM_W     = 43;
    localparam int ROOT_W    = (SUM_W + 1) / 2;
    localparam int ITER_W    = $clog2(SUM_W);
    localparam int RMS_W     = ROOT_W + 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 16;

    localparam logic [15:0] FULL_SCALE  = 16'h8000;
    localparam logic [15:0] DECAY_RESET = 16'd62259;
    localparam logic [15:0] GAIN_RESET  = 16'd1280;

    localparam logic [CFG_IDX_W-1:0] REG_DECAY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 1'b1;

    typedef struct packed {
        logic take;
        logic square;
        logic acc;
        logic div_load;
        logic div_step;
        logic root_load;
        logic root_step;
        logic env_upd;
        logic lvl_calc;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic close;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

FILE: hdl/rms_level_meter_peak_decay.sv
// top level of the rms level meter with peak-hold envelope and decay
`default_nettype none

// Takes one signed sample per request and closes a block on last, or when the
// block reaches MAX_BLOCK samples. A sample that does not close a block goes
// through accept, square and accumulate. A closing sample then goes through
// the bit-serial divider (one quotient bit per cycle over the 43-bit sum), the
// root load, the bit-serial integer square root (one root bit per cycle), the
// envelope update, the gain multiply and the output load, which registers its
// result. The result sits in an output register, so the next block is
// accepted while it waits to be taken; a second result waits in the controller
// until the first is gone. Configuration writes take effect at once.
module rms_level_meter_peak_decay #(
    parameter int MAX_BLOCK   = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_we,
    input  wire  [rmslm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire  [rmslm_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire                             i_valid,
    output logic                            o_ready,
    input  wire  signed [SAMPLE_BITS-1:0]   i_sample,
    input  wire                             i_last,
    output logic                            o_valid,
    input  wire                             i_ready,
    output logic [15:0]                     o_level,
    output logic [15:0]                     o_envelope
);
    import rmslm_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    rmslm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    rmslm_dp #(
        .MAX_BLOCK   (MAX_BLOCK),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_sample   (i_sample),
        .i_last     (i_last),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .i_ready    (i_ready),
        .o_valid    (o_valid),
        .o_level    (o_level),
        .o_envelope (o_envelope)
    );

endmodule

`default_nettype wire

FILE: hdl/rmslm_ctrl.sv
// sequencing state machine of the rms level meter
`default_nettype none
`include "rms_level_meter_peak_decay_macros.svh"

module rmslm_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_ready,
    input  rmslm_pkg::t_status i_status,
    output rmslm_pkg::t_cmd    o_cmd
);
    import rmslm_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_SQR       = 9'b000000010,
        S_ACC       = 9'b000000100,
        S_DIV       = 9'b000001000,
        S_ROOT_INIT = 9'b000010000,
        S_ROOT      = 9'b000100000,
        S_ENV       = 9'b001000000,
        S_LVL       = 9'b010000000,
        S_OUT       = 9'b100000000
    } t_state;

    localparam logic [ITER_W-1:0] LAST_DIV  = ITER_W'(SUM_W - 1);
    localparam logic [ITER_W-1:0] LAST_ROOT = ITER_W'(ROOT_W - 1);

    t_state            r_state, n_state;
    logic [ITER_W-1:0] r_iter, n_iter;

    always_comb begin
        n_state = r_state;
        n_iter  = r_iter;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_SQR;
                end
            end
            S_SQR: begin
                o_cmd.square = 1'b1;
                n_state      = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_iter    = '0;
                if (i_status.close) begin
                    o_cmd.div_load = 1'b1;
                    n_state        = S_DIV;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_iter == LAST_DIV) begin
                    n_iter  = '0;
                    n_state = S_ROOT_INIT;
                end else begin
                    n_iter = r_iter + 1'b1;
                end
            end
            S_ROOT_INIT: begin
                o_cmd.root_load = 1'b1;
                n_state         = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (r_iter == LAST_ROOT) begin
                    n_iter  = '0;
                    n_state = S_ENV;
                end else begin
                    n_iter = r_iter + 1'b1;
                end
            end
            S_ENV: begin
                o_cmd.env_upd = 1'b1;
                n_state       = S_LVL;
            end
            S_LVL: begin
                o_cmd.lvl_calc = 1'b1;
                n_state        = S_OUT;
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_iter  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_iter  <= '0;
        end else begin
            r_state <= n_state;
            r_iter  <= n_iter;
        end
    end

    assign o_ready = (r_state == S_IDLE);

    `RLM_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, o_cmd.take, !o_ready)
    `RLM_ASSERT_NEXT(a_root_after_div, i_clk, i_rst_n,
        r_state == S_DIV && r_iter == LAST_DIV, r_state == S_ROOT_INIT)
    `RLM_ASSERT_NEXT(a_out_holds, i_clk, i_rst_n,
        r_state == S_OUT && !i_status.out_free, r_state == S_OUT)

endmodule

`default_nettype wire

FILE: hdl/rmslm_dp.sv
// datapath: square-accumulate, serial divider, serial root, envelope and gain
`default_nettype none
`include "rms_level_meter_peak_decay_macros.svh"

module rmslm_dp #(
    parameter int MAX_BLOCK   = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_we,
    input  wire  [rmslm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire  [rmslm_pkg::CFG_W-1:0]          i_cfg_data,
    input  wire  signed [SAMPLE_BITS-1:0]        i_sample,
    input  wire                                  i_last,
    input  rmslm_pkg::t_cmd                      i_cmd,
    output rmslm_pkg::t_status                   o_status,
    input  wire                                  i_ready,
    output logic                                 o_valid,
    output logic [15:0]                          o_level,
    output logic [15:0]                          o_envelope
);
    import rmslm_pkg::*;

    localparam int CNT_W = $clog2(MAX_BLOCK + 1);
    localparam int SQ_W  = (2 * SAMPLE_BITS > SUM_W) ? 2 * SAMPLE_BITS : SUM_W;
    localparam int SH_L  = (SAMPLE_BITS < 16) ? 16 - SAMPLE_BITS : 0;
    localparam int SH_R  = (SAMPLE_BITS > 16) ? SAMPLE_BITS - 16 : 0;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCK);

    logic [15:0]            r_decay, r_gain;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic                   r_last;
    logic [SUM_W-1:0]       r_sq;
    logic [SUM_W-1:0]       r_sum;
    logic [CNT_W-1:0]       r_cnt;
    logic [SUM_W-1:0]       r_quo;
    logic [CNT_W-1:0]       r_den, r_rem;
    logic [SUM_W-1:0]       r_v, r_bit;
    logic [SUM_W:0]         r_res;
    logic [15:0]            r_env;
    logic [31:0]            r_prod;
    logic                   r_valid;
    logic [15:0]            r_level;
    logic [15:0]            r_out_env;

    logic [SAMPLE_BITS-1:0]   w_mag;
    logic [2*SAMPLE_BITS-1:0] w_sq;
    logic [SQ_W-1:0]          w_sq_ext;
    logic [SUM_W-1:0]         w_sum_new;
    logic [CNT_W-1:0]         w_cnt_new;
    logic [CNT_W:0]           w_trial, w_diff;
    logic                     w_qbit;
    logic [SUM_W:0]           w_rtrial;
    logic                     w_rfit;
    logic [RMS_W-1:0]         w_rms_wide;
    logic [15:0]              w_rms;
    logic [31:0]              w_decay_prod;
    logic [23:0]              w_lvl_wide;
    logic [15:0]              w_lvl;

    // magnitude and square
    assign w_mag    = r_sample[SAMPLE_BITS-1] ? (SAMPLE_BITS'(0) - r_sample) : r_sample;
    assign w_sq     = w_mag * w_mag;
    assign w_sq_ext = SQ_W'(w_sq);

    assign w_sum_new = r_sum + r_sq;
    assign w_cnt_new = r_cnt + 1'b1;

    // restoring divider step
    assign w_trial = {r_rem, r_quo[SUM_W-1]};
    assign w_qbit  = (w_trial >= {1'b0, r_den});
    assign w_diff  = w_trial - {1'b0, r_den};

    // root step
    assign w_rtrial = r_res + {1'b0, r_bit};
    assign w_rfit   = ({1'b0, r_v} >= w_rtrial);

    assign w_rms_wide   = (RMS_W'(r_res[ROOT_W-1:0]) << SH_L) >> SH_R;
    assign w_rms        = (w_rms_wide > RMS_W'(FULL_SCALE)) ? FULL_SCALE
                                                            : w_rms_wide[15:0];
    assign w_decay_prod = r_env * r_decay;

    assign w_lvl_wide = r_prod[31:8];
    assign w_lvl      = (w_lvl_wide > 24'(FULL_SCALE)) ? FULL_SCALE : w_lvl_wide[15:0];

    assign o_status.close    = r_last || (w_cnt_new >= CNT_MAX);
    assign o_status.out_free = !r_valid || i_ready;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decay <= DECAY_RESET;
            r_gain  <= GAIN_RESET;
            r_sum   <= '0;
            r_cnt   <= '0;
            r_env   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_DECAY: r_decay <= i_cfg_data;
                    REG_GAIN:  r_gain  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.acc) begin
                if (i_cmd.div_load) begin
                    r_sum <= '0;
                    r_cnt <= '0;
                end else begin
                    r_sum <= w_sum_new;
                    r_cnt <= w_cnt_new;
                end
            end
            if (i_cmd.env_upd) begin
                r_env <= (w_rms > r_env) ? w_rms : w_decay_prod[31:16];
            end
            if (i_cmd.out_load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_sample <= i_sample;
            r_last   <= i_last;
        end
        if (i_cmd.square) begin
            r_sq <= w_sq_ext[SUM_W-1:0];
        end
        if (i_cmd.div_load) begin
            r_quo <= w_sum_new;
            r_den <= w_cnt_new;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[SUM_W-2:0], w_qbit};
            r_rem <= w_qbit ? w_diff[CNT_W-1:0] : w_trial[CNT_W-1:0];
        end
        if (i_cmd.root_load) begin
            r_v   <= r_quo;
            r_res <= '0;
            r_bit <= {1'b1, {(SUM_W-1){1'b0}}};
        end else if (i_cmd.root_step) begin
            if (w_rfit) begin
                r_v   <= r_v - w_rtrial[SUM_W-1:0];
                r_res <= (r_res >> 1) + {1'b0, r_bit};
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (i_cmd.lvl_calc) begin
            r_prod <= r_env * r_gain;
        end
        if (i_cmd.out_load) begin
            r_level   <= w_lvl;
            r_out_env <= r_env;
        end
    end

    assign o_valid    = r_valid;
    assign o_level    = r_level;
    assign o_envelope = r_out_env;

    `RLM_ASSERT_IMPLIES(a_no_overwrite, i_clk, i_rst_n, i_cmd.out_load, !r_valid || i_ready)
    `RLM_ASSERT_IMPLIES(a_rem_below_den, i_clk, i_rst_n, i_cmd.div_step, r_rem < r_den)
    `RLM_ASSERT_IMPLIES(a_env_range, i_clk, i_rst_n, 1'b1, r_env <= FULL_SCALE)
    `RLM_ASSERT_IMPLIES(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt < CNT_MAX)

endmodule

`default_nettype wire
